// ----- rtl/fhf_pkg.sv -----
// Shared types, constants and handshake structs for the flame heat field block.
// Used by fhf_ctrl, fhf_dpath, flame_heat_field_update and fhf_checker.
// No dependencies.
`default_nettype none

package fhf_pkg;

    // Grid size limits; storage and address widths follow from these.
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;

    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    // Widths of the effective (clamped) counts.
    localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);

    // Configuration register reset values; the counts are held in 7-bit registers, max cooling in an 8-bit one.
    localparam logic [6:0] COLUMN_COUNT_RST = 7'((MAX_COLUMNS > 127) ? 127 : MAX_COLUMNS);
    localparam logic [6:0] ROW_COUNT_RST    = 7'((MAX_ROWS > 127) ? 127 : MAX_ROWS);
    localparam logic [7:0] MAX_COOLING_RST  = 8'd128;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd1;
    localparam logic [1:0] CFG_MAX_COOLING  = 2'd2;

    // Action codes.
    localparam logic [1:0] ACT_COOL  = 2'd0;
    localparam logic [1:0] ACT_DRIFT = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Division by three as multiplication by a reciprocal: (s * 683) >> 11 is
    // exact for every sum of three 8-bit values.
    localparam logic [10:0] RECIP3     = 11'd683;
    localparam int          DIV3_SHIFT = 11;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] column;
        logic [5:0] row;
        logic [7:0] amount;
    } t_in_item;

    typedef struct packed {
        logic [7:0] heat;
        logic       out_of_range;
    } t_out_item;

    // Read address sources.
    typedef enum logic [1:0] {
        RD_ITEM,
        RD_FLIP,
        RD_SCAN
    } t_rd_src;

    // Write address and data sources.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_COOL,
        WR_MEAN3,
        WR_MEAN2,
        WR_COPY,
        WR_SPARK
    } t_wr_src;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_src rd_src;
        logic    rd_load;
        logic    rd_dec;
        t_wr_src wr_src;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] in_action;
        logic       in_flag;
        logic       rows_gt2;
        logic       rd_zero;
        logic       dv_full;
        logic       clr_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- rtl/fhf_dpath.sv -----
// Datapath of the flame heat field block: configuration registers, heat memory,
// drift window and arithmetic, result payload register.
// Depends on fhf_pkg; driven by fhf_ctrl through t_dp_cmd.
`default_nettype none

module fhf_dpath (
    input  wire                logic       i_clk,
    input  wire                logic       i_rst_n,
    input  wire                logic       i_cfg_we,
    input  wire                logic [1:0] i_cfg_index,
    input  wire                logic [7:0] i_cfg_data,
    input  wire fhf_pkg::t_in_item         i_in_item,
    input  wire fhf_pkg::t_dp_cmd          i_cmd,
    output fhf_pkg::t_dp_sts               o_sts,
    output fhf_pkg::t_out_item             o_out_item
);

    localparam int COL_W  = fhf_pkg::COL_W;
    localparam int ROW_W  = fhf_pkg::ROW_W;
    localparam int ADDR_W = fhf_pkg::ADDR_W;
    localparam int CCNT_W = fhf_pkg::CCNT_W;
    localparam int RCNT_W = fhf_pkg::RCNT_W;

    logic [6:0] r_col_count;
    logic [6:0] r_row_count;
    logic [7:0] r_max_cool;

    fhf_pkg::t_in_item  r_item;
    logic               r_flag;
    fhf_pkg::t_out_item r_out;

    logic [7:0] r_mem [fhf_pkg::DEPTH];
    logic [7:0] r_rd_data;

    logic [ROW_W-1:0]  r_rd;
    logic              r_dv;
    logic [ROW_W-1:0]  r_dv_row;
    logic [7:0]        r_w1;
    logic [7:0]        r_w2;
    logic [1:0]        r_nrx;
    logic [ADDR_W-1:0] r_clr;

    logic [CCNT_W-1:0] eff_cols;
    logic [RCNT_W-1:0] eff_rows;
    logic              in_col_bad;
    logic              in_row_bad;
    logic              in_flag;

    logic [ROW_W-1:0]  flip_row;
    logic [ROW_W-1:0]  rd_row;
    logic [ADDR_W-1:0] rd_addr;
    logic [ROW_W-1:0]  wr_row;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              wr_en;

    logic [7:0]  cool_amt;
    logic [7:0]  cool_val;
    logic [9:0]  sum3;
    logic [20:0] prod3;
    logic [7:0]  mean3;
    logic [8:0]  sum2;

    // A count of zero acts as one; a count beyond the grid acts as the grid size.
    always_comb begin
        if (r_col_count == 7'd0) begin
            eff_cols = CCNT_W'(1);
        end else if (32'(r_col_count) > 32'(fhf_pkg::MAX_COLUMNS)) begin
            eff_cols = CCNT_W'(fhf_pkg::MAX_COLUMNS);
        end else begin
            eff_cols = CCNT_W'(r_col_count);
        end
        if (r_row_count == 7'd0) begin
            eff_rows = RCNT_W'(1);
        end else if (32'(r_row_count) > 32'(fhf_pkg::MAX_ROWS)) begin
            eff_rows = RCNT_W'(fhf_pkg::MAX_ROWS);
        end else begin
            eff_rows = RCNT_W'(r_row_count);
        end
    end

    assign in_col_bad = 32'(i_in_item.column) >= 32'(eff_cols);
    assign in_row_bad = 32'(i_in_item.row) >= 32'(eff_rows);

    always_comb begin
        unique case (i_in_item.action)
            fhf_pkg::ACT_COOL:  in_flag = in_col_bad | in_row_bad;
            fhf_pkg::ACT_DRIFT: in_flag = in_col_bad;
            fhf_pkg::ACT_READ:  in_flag = in_col_bad | in_row_bad;
            default:            in_flag = 1'b0;
        endcase
    end

    // Read rows are counted from the top.
    assign flip_row = ROW_W'(32'(eff_rows) - 32'd1 - 32'(r_item.row));

    always_comb begin
        unique case (i_cmd.rd_src)
            fhf_pkg::RD_ITEM: rd_row = ROW_W'(r_item.row);
            fhf_pkg::RD_FLIP: rd_row = flip_row;
            fhf_pkg::RD_SCAN: rd_row = r_rd;
            default:          rd_row = r_rd;
        endcase
    end
    assign rd_addr = {COL_W'(r_item.column), rd_row};

    assign cool_amt = (r_item.amount > r_max_cool) ? r_max_cool : r_item.amount;
    assign cool_val = (r_rd_data > cool_amt) ? (r_rd_data - cool_amt) : 8'd0;

    // Newest read value plus the two rows above it in the window.
    assign sum3  = 10'(r_rd_data) + 10'(r_w1) + 10'(r_w2);
    assign prod3 = 21'(sum3) * 21'(fhf_pkg::RECIP3);
    assign mean3 = prod3[fhf_pkg::DIV3_SHIFT +: 8];
    assign sum2  = 9'(r_w1) + 9'(r_w2);

    always_comb begin
        wr_en   = 1'b1;
        wr_row  = ROW_W'(r_item.row);
        wr_data = 8'd0;
        unique case (i_cmd.wr_src)
            fhf_pkg::WR_NONE: begin
                wr_en = 1'b0;
            end
            fhf_pkg::WR_CLEAR: begin
                wr_data = 8'd0;
            end
            fhf_pkg::WR_COOL: begin
                wr_data = cool_val;
            end
            fhf_pkg::WR_MEAN3: begin
                wr_row  = ROW_W'(32'(r_dv_row) + 32'd3);
                wr_data = mean3;
            end
            fhf_pkg::WR_MEAN2: begin
                wr_row  = ROW_W'(2);
                wr_data = sum2[8:1];
            end
            fhf_pkg::WR_COPY: begin
                wr_row  = ROW_W'(1);
                wr_data = r_w1;
            end
            fhf_pkg::WR_SPARK: begin
                wr_row  = '0;
                wr_data = r_item.amount;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end
    assign wr_addr = (i_cmd.wr_src == fhf_pkg::WR_CLEAR) ? r_clr
                                                         : {COL_W'(r_item.column), wr_row};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= fhf_pkg::COLUMN_COUNT_RST;
            r_row_count <= fhf_pkg::ROW_COUNT_RST;
            r_max_cool  <= fhf_pkg::MAX_COOLING_RST;
            r_clr       <= '0;
            r_dv        <= 1'b0;
            r_nrx       <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fhf_pkg::CFG_COLUMN_COUNT: r_col_count <= i_cfg_data[6:0];
                    fhf_pkg::CFG_ROW_COUNT:    r_row_count <= i_cfg_data[6:0];
                    fhf_pkg::CFG_MAX_COOLING:  r_max_cool  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.wr_src == fhf_pkg::WR_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            r_dv <= i_cmd.rd_dec;
            if (i_cmd.rd_load) begin
                r_nrx <= 2'd0;
            end else if (r_dv && r_nrx != 2'd2) begin
                r_nrx <= r_nrx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
            r_flag <= in_flag;
        end
        if (i_cmd.rd_load) begin
            r_rd <= ROW_W'(32'(eff_rows) - 32'd2);
        end else if (i_cmd.rd_dec) begin
            r_rd <= r_rd - 1'b1;
        end
        r_dv_row <= r_rd;
        if (r_dv) begin
            r_w1 <= r_rd_data;
            r_w2 <= r_w1;
        end
        if (i_cmd.out_load) begin
            r_out.heat <= (r_item.action == fhf_pkg::ACT_READ && !r_flag) ? r_rd_data
                                                                            : 8'd0;
            r_out.out_of_range <= r_flag;
        end
    end

    assign o_sts.in_action = i_in_item.action;
    assign o_sts.in_flag   = in_flag;
    assign o_sts.rows_gt2  = 32'(eff_rows) > 32'd2;
    assign o_sts.rd_zero   = (r_rd == '0);
    assign o_sts.dv_full   = r_dv && (r_nrx == 2'd2);
    assign o_sts.clr_last  = (r_clr == {ADDR_W{1'b1}});

    assign o_out_item = r_out;

endmodule

`default_nettype wire

// ----- rtl/fhf_ctrl.sv -----
// Controller of the flame heat field block: sequences the clearing pass, the
// cool, read and drift actions, and owns the input and output handshakes.
// Depends on fhf_pkg; drives fhf_dpath through t_dp_cmd.
`default_nettype none

module fhf_ctrl (
    input  wire              logic i_clk,
    input  wire              logic i_rst_n,
    input  wire              logic i_in_valid,
    output                   logic o_in_ready,
    output                   logic o_out_valid,
    input  wire              logic i_out_ready,
    input  wire fhf_pkg::t_dp_sts  i_sts,
    output fhf_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_COOL_RD,
        S_COOL_WR,
        S_READ_RD,
        S_DR_RD,
        S_DR_LAST,
        S_DR_MEAN2,
        S_DR_COPY,
        S_DR_SPARK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_src = fhf_pkg::RD_ITEM;
        o_cmd.wr_src = fhf_pkg::WR_NONE;
        n_state      = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_src = fhf_pkg::WR_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.rd_load = 1'b1;
                    priority if (i_sts.in_flag) begin
                        n_state = S_DONE;
                    end else if (i_sts.in_action == fhf_pkg::ACT_COOL) begin
                        n_state = S_COOL_RD;
                    end else if (i_sts.in_action == fhf_pkg::ACT_READ) begin
                        n_state = S_READ_RD;
                    end else if (i_sts.in_action == fhf_pkg::ACT_DRIFT) begin
                        n_state = i_sts.rows_gt2 ? S_DR_RD : S_DR_SPARK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_COOL_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_COOL_WR;
            end
            S_COOL_WR: begin
                o_cmd.wr_src = fhf_pkg::WR_COOL;
                n_state      = S_DONE;
            end
            S_READ_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = fhf_pkg::RD_FLIP;
                n_state      = S_DONE;
            end
            // Rows are read downwards one a cycle; each arrival with two rows
            // above it in the window writes the mean three rows higher.
            S_DR_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = fhf_pkg::RD_SCAN;
                o_cmd.rd_dec = 1'b1;
                if (i_sts.dv_full) begin
                    o_cmd.wr_src = fhf_pkg::WR_MEAN3;
                end
                if (i_sts.rd_zero) begin
                    n_state = S_DR_LAST;
                end
            end
            S_DR_LAST: begin
                if (i_sts.dv_full) begin
                    o_cmd.wr_src = fhf_pkg::WR_MEAN3;
                end
                n_state = S_DR_MEAN2;
            end
            S_DR_MEAN2: begin
                o_cmd.wr_src = fhf_pkg::WR_MEAN2;
                n_state      = S_DR_COPY;
            end
            S_DR_COPY: begin
                o_cmd.wr_src = fhf_pkg::WR_COPY;
                n_state      = S_DR_SPARK;
            end
            S_DR_SPARK: begin
                o_cmd.wr_src = fhf_pkg::WR_SPARK;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/flame_heat_field_update.sv -----
// Top level of the flame heat field block: joins the controller and datapath.
// Depends on fhf_pkg, fhf_ctrl and fhf_dpath.
//
// Usage:
// Items arrive on the input channel (i_in_valid / o_in_ready / i_in_item) and
// each gives exactly one result item on the output channel (o_out_valid /
// i_out_ready / o_out_item). Items are worked on one at a time.
// A read is one memory read, a cool a read then a write back through the
// single memory write port, and a flagged or unused action goes straight to
// the result. A drift with more than two rows scans the column one row a cycle
// through the memory read port and then makes the three bottom-row writes;
// with fewer rows it writes only the bottom row. The next item is accepted in
// the cycle after the result is loaded into the output register.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
// once and are accepted at any time, but belong between items.
// After reset the whole heat memory is cleared one cell a cycle, during which
// o_in_ready stays low.
// A result waits in the output register while the receiver stalls; the next
// item may be accepted meanwhile, but its result is held back until the
// waiting one has been taken.
`default_nettype none

module flame_heat_field_update (
    input  wire                logic       i_clk,
    input  wire                logic       i_rst_n,
    input  wire                logic       i_in_valid,
    output                     logic       o_in_ready,
    input  wire fhf_pkg::t_in_item         i_in_item,
    output                     logic       o_out_valid,
    input  wire                logic       i_out_ready,
    output fhf_pkg::t_out_item             o_out_item,
    input  wire                logic       i_cfg_we,
    input  wire                logic [1:0] i_cfg_index,
    input  wire                logic [7:0] i_cfg_data
);

    fhf_pkg::t_dp_cmd cmd;
    fhf_pkg::t_dp_sts sts;

    fhf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fhf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ----- rtl/fhf_checker.sv -----
// Port-level checks for the flame heat field block, bound to its top level.
// Depends on fhf_pkg; sees only the ports of flame_heat_field_update.
`default_nettype none

module fhf_checker (
    input wire                logic i_clk,
    input wire                logic i_rst_n,
    input wire                logic i_in_valid,
    input wire                logic o_in_ready,
    input wire                logic o_out_valid,
    input wire                logic i_out_ready,
    input wire fhf_pkg::t_out_item  o_out_item
);

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // The memory clearing pass keeps the input closed straight after reset.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready during clearing pass");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Items are processed one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted while another is in work");

    // A flagged result never carries heat.
    a_flag_no_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.out_of_range |-> o_out_item.heat == 8'd0)
        else $error("out-of-range result with nonzero heat");

endmodule

bind flame_heat_field_update fhf_checker u_fhf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ----- tb/tb_flame_heat_field_update.sv -----
// Self-checking testbench for flame_heat_field_update: directed table, then random phases.
// Predicts results from its own heat field model, apart from typed table rows; depends on fhf_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_flame_heat_field_update;

    localparam logic [1:0] ACT_COOL   = fhf_pkg::ACT_COOL;
    localparam logic [1:0] ACT_DRIFT  = fhf_pkg::ACT_DRIFT;
    localparam logic [1:0] ACT_READ   = fhf_pkg::ACT_READ;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         N_DIRECTED = 30;
    localparam int         N_PHASES   = 6;
    localparam int         PHASE_ITEMS = 75;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_SETTINGS
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] action;
        logic [5:0] column;
        logic [5:0] row;
        logic [7:0] amount;
        logic [7:0] want_heat;
        logic       want_flag;
        logic [7:0] cfg_cols;
        logic [7:0] cfg_rows;
        logic [7:0] cfg_cool;
    } t_tbl_row;

    typedef struct packed {
        logic [7:0] cols;
        logic [7:0] rows;
        logic [7:0] cool;
    } t_grid_setting;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    fhf_pkg::t_in_item  i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    fhf_pkg::t_out_item o_out_item;
    logic               i_cfg_we    = 1'b0;
    logic [1:0]         i_cfg_index = fhf_pkg::CFG_COLUMN_COUNT;
    logic [7:0]         i_cfg_data  = '0;

    // Model state: the heat field and the register copies.
    logic [7:0] field [fhf_pkg::MAX_COLUMNS][fhf_pkg::MAX_ROWS];
    logic [6:0] column_count_r = fhf_pkg::COLUMN_COUNT_RST;
    logic [6:0] row_count_r    = fhf_pkg::ROW_COUNT_RST;
    logic [7:0] max_cooling_r  = fhf_pkg::MAX_COOLING_RST;

    fhf_pkg::t_out_item heat_results_due [$];
    int                 mismatch_count = 0;
    bit                 no_gaps = 1'b0;

    t_tbl_row directed_tbl [N_DIRECTED] = '{
        '{ROW_TYPED,    ACT_READ,   6'd0,  6'd0,  8'd0,   8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_TYPED,    ACT_READ,   6'd63, 6'd63, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_TYPED,    ACT_DRIFT,  6'd0,  6'd0,  8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_TYPED,    ACT_DRIFT,  6'd0,  6'd63, 8'd200, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_READ,   6'd0,  6'd63, 8'd0,   8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_READ,   6'd0,  6'd62, 8'd0,   8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_COOL,   6'd0,  6'd0,  8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_READ,   6'd0,  6'd63, 8'd0,   8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_COOL,   6'd63, 6'd63, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_TYPED,    ACT_UNUSED, 6'd63, 6'd63, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_SETTINGS, ACT_COOL,   6'd0,  6'd0,  8'd0,   8'd0, 1'b0, 8'd4, 8'd8, 8'd255},
        '{ROW_TYPED,    ACT_COOL,   6'd4,  6'd0,  8'd10,  8'd0, 1'b1, 8'd0, 8'd0, 8'd0},
        '{ROW_TYPED,    ACT_COOL,   6'd0,  6'd8,  8'd10,  8'd0, 1'b1, 8'd0, 8'd0, 8'd0},
        '{ROW_TYPED,    ACT_READ,   6'd0,  6'd8,  8'd0,   8'd0, 1'b1, 8'd0, 8'd0, 8'd0},
        '{ROW_TYPED,    ACT_DRIFT,  6'd4,  6'd0,  8'd255, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_DRIFT,  6'd0,  6'd63, 8'd77,  8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_READ,   6'd0,  6'd5,  8'd0,   8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_SETTINGS, ACT_COOL,   6'd0,  6'd0,  8'd0,   8'd0, 1'b0, 8'd1, 8'd2, 8'd0},
        '{ROW_PREDICT,  ACT_DRIFT,  6'd0,  6'd0,  8'd9,   8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_READ,   6'd0,  6'd1,  8'd0,   8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_COOL,   6'd0,  6'd0,  8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_TYPED,    ACT_READ,   6'd1,  6'd0,  8'd0,   8'd0, 1'b1, 8'd0, 8'd0, 8'd0},
        '{ROW_SETTINGS, ACT_COOL,   6'd0,  6'd0,  8'd0,   8'd0, 1'b0, 8'd0, 8'd0, 8'hFF},
        '{ROW_PREDICT,  ACT_DRIFT,  6'd0,  6'd0,  8'd128, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_COOL,   6'd0,  6'd0,  8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_READ,   6'd0,  6'd0,  8'd0,   8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_TYPED,    ACT_READ,   6'd0,  6'd1,  8'd0,   8'd0, 1'b1, 8'd0, 8'd0, 8'd0},
        '{ROW_SETTINGS, ACT_COOL,   6'd0,  6'd0,  8'd0,   8'd0, 1'b0, 8'hFF, 8'd100, 8'd128},
        '{ROW_PREDICT,  ACT_READ,   6'd0,  6'd0,  8'd0,   8'd0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{ROW_PREDICT,  ACT_READ,   6'd0,  6'd61, 8'd0,   8'd0, 1'b0, 8'd0, 8'd0, 8'd0}
    };

    // Data above bit 6 of a count is dropped; 8'h50 gives 80, beyond the grid.
    t_grid_setting phase_settings [N_PHASES] = '{
        '{8'd4,  8'd8,  8'd255},
        '{8'd64, 8'd64, 8'd128},
        '{8'd2,  8'd3,  8'd0},
        '{8'd1,  8'd64, 8'd40},
        '{8'h50, 8'd2,  8'd7},
        '{8'd12, 8'd16, 8'd255}
    };

    flame_heat_field_update dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A count of zero behaves as one, and one beyond the grid as the grid size.
    function automatic int used_count(logic [6:0] v, int lim);
        if (v == 0)
            return 1;
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic fhf_pkg::t_out_item advance_heat_field(fhf_pkg::t_in_item it);
        fhf_pkg::t_out_item res;
        int                 cols;
        int                 rows;
        int                 c;
        int                 r;
        int                 cool;
        int                 sum;
        cols = used_count(column_count_r, fhf_pkg::MAX_COLUMNS);
        rows = used_count(row_count_r, fhf_pkg::MAX_ROWS);
        c    = int'(it.column);
        r    = int'(it.row);
        res  = '0;
        case (it.action)
            ACT_COOL: begin
                if (c >= cols || r >= rows) begin
                    res.out_of_range = 1'b1;
                end else begin
                    cool = (int'(it.amount) > int'(max_cooling_r)) ?
                           int'(max_cooling_r) : int'(it.amount);
                    field[c][r] = (int'(field[c][r]) > cool) ? 8'(int'(field[c][r]) - cool) : 8'd0;
                end
            end
            ACT_DRIFT: begin
                if (c >= cols) begin
                    res.out_of_range = 1'b1;
                end else begin
                    // Walk downwards so each mean uses cells not yet rewritten.
                    for (int y = rows - 1; y >= 3; y--) begin
                        sum = int'(field[c][y-1]) + int'(field[c][y-2]) + int'(field[c][y-3]);
                        field[c][y] = 8'(sum / 3);
                    end
                    if (rows > 2) begin
                        sum = int'(field[c][1]) + int'(field[c][0]);
                        field[c][2] = 8'(sum / 2);
                        field[c][1] = field[c][0];
                    end
                    field[c][0] = it.amount;
                end
            end
            ACT_READ: begin
                if (c >= cols || r >= rows)
                    res.out_of_range = 1'b1;
                else
                    res.heat = field[c][rows - 1 - r];
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic fhf_pkg::t_in_item random_heat_item();
        fhf_pkg::t_in_item it;
        int                pick;
        pick      = $urandom_range(99);
        it.column = 6'($urandom_range(used_count(column_count_r, fhf_pkg::MAX_COLUMNS) - 1));
        it.row    = 6'($urandom_range(used_count(row_count_r, fhf_pkg::MAX_ROWS) - 1));
        it.amount = 8'($urandom);
        if (pick < 35) begin
            it.action = ACT_DRIFT;
        end else if (pick < 65) begin
            it.action = ACT_READ;
        end else if (pick < 88) begin
            it.action = ACT_COOL;
        end else if (pick < 96) begin
            // Anywhere in the address space, so mostly flagged on small grids.
            it.action = 2'($urandom_range(2));
            it.column = 6'($urandom);
            it.row    = 6'($urandom);
        end else begin
            it.action = ACT_UNUSED;
            it.column = 6'($urandom);
            it.row    = 6'($urandom);
        end
        return it;
    endfunction

    // Present one item and hold it until taken; the expectation is queued at acceptance.
    task automatic send_item(fhf_pkg::t_in_item it, bit typed, fhf_pkg::t_out_item typed_res);
        fhf_pkg::t_out_item predicted;
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        predicted = advance_heat_field(it);
        heat_results_due.push_back(typed ? typed_res : predicted);
    endtask

    task automatic sender_gap();
        if (!no_gaps) begin
            while ($urandom_range(99) < 29) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (heat_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_grid_setting(t_grid_setting s);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= fhf_pkg::CFG_COLUMN_COUNT;
        i_cfg_data  <= s.cols;
        @(posedge i_clk);
        column_count_r = s.cols[6:0];
        i_cfg_index <= fhf_pkg::CFG_ROW_COUNT;
        i_cfg_data  <= s.rows;
        @(posedge i_clk);
        row_count_r = s.rows[6:0];
        i_cfg_index <= fhf_pkg::CFG_MAX_COOLING;
        i_cfg_data  <= s.cool;
        @(posedge i_clk);
        max_cooling_r = s.cool;
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk)
        i_out_ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 29);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (heat_results_due.size() == 0) begin
                $display("%0t: unexpected result item: expected none, got heat %0d flag %0b",
                         $time, o_out_item.heat, o_out_item.out_of_range);
                mismatch_count++;
            end else begin
                if (o_out_item.heat !== heat_results_due[0].heat) begin
                    $display("%0t: heat: expected %0d, got %0d",
                             $time, heat_results_due[0].heat, o_out_item.heat);
                    mismatch_count++;
                end
                if (o_out_item.out_of_range !== heat_results_due[0].out_of_range) begin
                    $display("%0t: out_of_range: expected %0b, got %0b",
                             $time, heat_results_due[0].out_of_range, o_out_item.out_of_range);
                    mismatch_count++;
                end
                void'(heat_results_due.pop_front());
            end
        end
    end

    initial begin
        fhf_pkg::t_in_item  it;
        fhf_pkg::t_out_item typed_res;
        foreach (field[c, r])
            field[c][r] = 8'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_tbl[k]) begin
            if (directed_tbl[k].kind == ROW_SETTINGS) begin
                wait_results_drained();
                load_grid_setting('{directed_tbl[k].cfg_cols, directed_tbl[k].cfg_rows,
                                    directed_tbl[k].cfg_cool});
            end else begin
                it        = '{directed_tbl[k].action, directed_tbl[k].column,
                              directed_tbl[k].row, directed_tbl[k].amount};
                typed_res = '{directed_tbl[k].want_heat, directed_tbl[k].want_flag};
                sender_gap();
                send_item(it, directed_tbl[k].kind == ROW_TYPED, typed_res);
            end
        end

        // One phase runs without the random sender gaps and receiver stalls.
        for (int p = 0; p < N_PHASES; p++) begin
            wait_results_drained();
            load_grid_setting(phase_settings[p]);
            no_gaps = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sender_gap();
                send_item(random_heat_item(), 1'b0, '0);
                if ($urandom_range(49) == 0)
                    wait_results_drained();
            end
        end
        no_gaps = 1'b0;

        wait_results_drained();
        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- flame_heat_field_update.f -----
rtl/fhf_pkg.sv
rtl/fhf_dpath.sv
rtl/fhf_ctrl.sv
rtl/flame_heat_field_update.sv
rtl/fhf_checker.sv
tb/tb_flame_heat_field_update.sv
